// File: design/bdi_line_size_selector_core_defines.svh
// Assertion macros shared by the line size selector RTL.
`ifndef BDI_LINE_SIZE_SELECTOR_CORE_DEFINES_SVH
`define BDI_LINE_SIZE_SELECTOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge outside reset.
`define BDI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising clock edge, reset included.
`define BDI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDI_ASSERT(label, prop, msg)
`define BDI_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: design/bdi_lss_pkg.sv
// Constants, tables and helper functions of the base-delta line size selector.
`default_nettype none

package bdi_lss_pkg;

    // Line and page geometry.
    localparam int LINE_BYTES = 64;
    localparam int PAGE_BYTES = 4096;

    // Option flags: zero, four repeat grains, seven 8-byte, three 4-byte, one 2-byte.
    localparam int NUM_FLAGS = 16;
    localparam int FLAG_W    = $clog2(NUM_FLAGS);

    localparam int FLAG_ZERO     = 0;
    localparam int FLAG_REP1     = 1;
    localparam int FLAG_REP2     = 2;
    localparam int FLAG_REP4     = 3;
    localparam int FLAG_REP8     = 4;
    localparam int FLAG_B8_FIRST = 5;
    localparam int FLAG_B4_FIRST = 12;
    localparam int FLAG_B2       = 15;

    // Option codes as they appear on the result.
    localparam int NUM_CANDS = 16;
    typedef logic [4:0] code_t;
    localparam code_t CODE_ZERO     = 5'd0;
    localparam code_t CODE_BD_FIRST = 5'd5;
    localparam code_t CODE_NONE     = 5'd16;

    typedef logic [6:0] line_size_t;
    typedef logic [NUM_FLAGS-1:0] flags_t;

    // Page accounting: the byte sum and line count only need to saturate just past
    // the point where the page total is known to overflow.
    localparam int SUM_CAP_I = PAGE_BYTES + 1;
    localparam int CNT_CAP_I = 2 * PAGE_BYTES + 2;
    localparam int SUM_W     = $clog2(SUM_CAP_I + 1);
    localparam int CNT_W     = $clog2(CNT_CAP_I + 1);
    localparam int TOT_W     = $clog2(SUM_CAP_I + CNT_CAP_I / 2 + 1);
    localparam int GOOD_W    = 7;
    localparam int PAGE_OUT_W = 13;

    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [SUM_W:0]        sum_ext_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CNT_W:0]        cnt_ext_t;
    typedef logic [TOT_W-1:0]      total_t;
    typedef logic [GOOD_W-1:0]     good_t;
    typedef logic [PAGE_OUT_W-1:0] page_bytes_t;

    localparam sum_t        SUM_CAP   = sum_t'(SUM_CAP_I);
    localparam cnt_t        CNT_CAP   = cnt_t'(CNT_CAP_I);
    localparam good_t       GOOD_CAP  = '1;
    localparam total_t      PAGE_TOT  = total_t'(PAGE_BYTES);
    localparam page_bytes_t PAGE_CLIP = page_bytes_t'(PAGE_BYTES);

    // Candidate tables indexed by option code, for the original six-option set.
    localparam int ORG_FLAG [NUM_CANDS] = '{0, 1, 2, 3, 4, 5, 6, 8, 12, 13, 15,
                                            0, 0, 0, 0, 0};
    localparam bit ORG_USED [NUM_CANDS] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                                            0, 0, 0, 0, 0};
    localparam int ORG_KLOG [NUM_CANDS] = '{0, 0, 0, 0, 0, 3, 3, 3, 2, 2, 1,
                                            0, 0, 0, 0, 0};
    localparam int ORG_D    [NUM_CANDS] = '{0, 0, 0, 0, 0, 1, 2, 4, 1, 2, 1,
                                            0, 0, 0, 0, 0};

    // Candidate tables for the extended eleven-option set.
    localparam int EXT_FLAG [NUM_CANDS] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10,
                                            11, 12, 13, 14, 15};
    localparam int EXT_KLOG [NUM_CANDS] = '{0, 0, 0, 0, 0, 3, 3, 3, 3, 3, 3,
                                            3, 2, 2, 2, 1};
    localparam int EXT_D    [NUM_CANDS] = '{0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6,
                                            7, 1, 2, 3, 1};

    // Sign extension of a 32-bit or 16-bit element to a full word.
    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Whether an option code belongs to the selected set.
    function automatic bit cand_used(input bit ext, input int c);
        return ext ? 1'b1 : ORG_USED[c];
    endfunction

    // Flag bit that tracks an option code.
    function automatic int cand_flag(input bit ext, input int c);
        return ext ? EXT_FLAG[c] : ORG_FLAG[c];
    endfunction

    // Encoded line size of an option code, in bytes.
    function automatic int cand_size(input bit ext, input int c);
        int klog;
        int d;
        klog = ext ? EXT_KLOG[c] : ORG_KLOG[c];
        d    = ext ? EXT_D[c] : ORG_D[c];
        if (c == int'(CODE_ZERO))
            return 1;
        if (c < int'(CODE_BD_FIRST))
            return 1 << (c - 1);
        return (1 << klog) + ((LINE_BYTES >> klog) * d);
    endfunction

    // True when option j wins over option i: smaller, or equal and lower code.
    function automatic bit cand_beats(input bit ext, input int j, input int i);
        int sj;
        int si;
        sj = cand_size(ext, j);
        si = cand_size(ext, i);
        return (sj < si) || ((sj == si) && (j < i));
    endfunction

endpackage

`default_nettype wire

// File: design/bdi_line_size_selector_core.sv
// Base-delta-immediate line size selector: per-word flag checks and per-line option choice.
`default_nettype none
`include "bdi_line_size_selector_core_defines.svh"

// The block takes one 64-bit line word per cycle with no gaps needed between lines.
// A transfer lands in an input register; from there one pass of flag logic
// (a handful of parallel 64-bit subtractors and compares) clears the options the
// word rules out, and on the line's last word picks the winning encoding and
// writes the result register, from which the result is shown, once it is free.
// The input side stalls only while the input register holds a line-ending word
// and the result register is still full and stalled. The option set register
// must be written only while no line is in flight.
module bdi_line_size_selector_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration: one register, the extended option set enable.
    input  wire logic        cfg_write,
    input  wire logic        cfg_data,

    // Input channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] line_word,
    input  wire logic        line_end,
    input  wire logic        page_end,

    // Result channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       option_code,
    output logic [6:0]       line_bytes_out,
    output logic             line_was_compressed,
    output logic             page_valid,
    output logic [12:0]      page_bytes_out,
    output logic [6:0]       page_lines_compressed,
    output logic             page_overflowed
);

    // Configuration register.
    logic use_extra_reg;

    // Input register.
    logic        s1_valid_reg;
    logic [63:0] s1_word_reg;
    logic        s1_line_end_reg;
    logic        s1_page_end_reg;

    // Line state.
    logic                 first_pending_reg;
    logic [63:0]          first_word_reg;
    bdi_lss_pkg::flags_t  flags_reg;

    // Page state.
    bdi_lss_pkg::sum_t  page_sum_reg;
    bdi_lss_pkg::cnt_t  page_cnt_reg;
    bdi_lss_pkg::good_t page_good_reg;

    // Result register.
    logic                      out_valid_reg;
    bdi_lss_pkg::code_t        code_reg;
    bdi_lss_pkg::line_size_t   size_reg;
    logic                      compressed_reg;
    logic                      page_valid_reg;
    bdi_lss_pkg::page_bytes_t  page_bytes_reg;
    bdi_lss_pkg::good_t        page_good_out_reg;
    logic                      page_ovf_reg;

    // Handshake and datapath signals.
    logic                      in_xfer;
    logic                      s1_ends;
    logic                      out_free;
    logic                      s1_adv;
    logic                      s1_emit;
    logic [63:0]               base_word;
    bdi_lss_pkg::flags_t       clr;
    bdi_lss_pkg::flags_t       flags_new;
    logic [63:0]               d8;
    logic [1:0][63:0]          d4;
    logic [3:0][63:0]          d2;
    logic [1:0][bdi_lss_pkg::NUM_CANDS-1:0] elig;
    logic [1:0][bdi_lss_pkg::NUM_CANDS-1:0] win;
    logic [bdi_lss_pkg::NUM_CANDS-1:0]      sel;
    bdi_lss_pkg::code_t        best_code;
    bdi_lss_pkg::line_size_t   best_size;
    logic                      compressed;
    bdi_lss_pkg::sum_ext_t     sum_add;
    bdi_lss_pkg::sum_t         sum_sat;
    bdi_lss_pkg::cnt_ext_t     cnt_add;
    bdi_lss_pkg::cnt_t         cnt_sat;
    bdi_lss_pkg::good_t        good_sat;
    bdi_lss_pkg::total_t       page_total;
    logic                      page_ovf;
    bdi_lss_pkg::page_bytes_t  page_bytes;

    // Handshake control: words that do not end a line never wait on the output.
    assign in_xfer  = in_valid && !in_stall;
    assign s1_ends  = s1_line_end_reg || s1_page_end_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_ends || out_free);
    assign s1_emit  = s1_adv && s1_ends;
    assign in_stall = s1_valid_reg && !s1_adv;

    // The first word of a line serves as its own base.
    assign base_word = first_pending_reg ? s1_word_reg : first_word_reg;

    // Flag checks for one word against the line's base.
    always_comb
    begin
        clr = '0;
        clr[bdi_lss_pkg::FLAG_ZERO] = |s1_word_reg;

        // Repeated value at each grain.
        for (int j = 0; j < 8; j++)
        begin
            if (s1_word_reg[8*j +: 8] != base_word[7:0])
                clr[bdi_lss_pkg::FLAG_REP1] = 1'b1;
        end
        for (int j = 0; j < 4; j++)
        begin
            if (s1_word_reg[16*j +: 16] != base_word[15:0])
                clr[bdi_lss_pkg::FLAG_REP2] = 1'b1;
        end
        for (int j = 0; j < 2; j++)
        begin
            if (s1_word_reg[32*j +: 32] != base_word[31:0])
                clr[bdi_lss_pkg::FLAG_REP4] = 1'b1;
        end
        if (s1_word_reg != base_word)
            clr[bdi_lss_pkg::FLAG_REP8] = 1'b1;

        // 8-byte base: the delta must fit in d bytes.
        d8 = base_word - s1_word_reg;
        for (int d = 1; d < 8; d++)
        begin
            if ((d8 >> (8 * d)) != 64'd0)
                clr[bdi_lss_pkg::FLAG_W'(bdi_lss_pkg::FLAG_B8_FIRST + d - 1)] = 1'b1;
        end

        // 4-byte base over both halves of the word.
        for (int j = 0; j < 2; j++)
        begin
            d4[j] = bdi_lss_pkg::sext32(base_word[31:0])
                  - bdi_lss_pkg::sext32(s1_word_reg[32*j +: 32]);
            for (int d = 1; d < 4; d++)
            begin
                if ((d4[j] >> (8 * d)) != 64'd0)
                    clr[bdi_lss_pkg::FLAG_W'(bdi_lss_pkg::FLAG_B4_FIRST + d - 1)] = 1'b1;
            end
        end

        // 2-byte base with a one-byte delta.
        for (int j = 0; j < 4; j++)
        begin
            d2[j] = bdi_lss_pkg::sext16(base_word[15:0])
                  - bdi_lss_pkg::sext16(s1_word_reg[16*j +: 16]);
            if ((d2[j] >> 8) != 64'd0)
                clr[bdi_lss_pkg::FLAG_B2] = 1'b1;
        end
    end

    assign flags_new = flags_reg & ~clr;

    // Winner search for both option sets; each candidate checks every rival in parallel.
    always_comb
    begin
        logic beaten;
        elig   = '0;
        win    = '0;
        beaten = 1'b0;
        for (int m = 0; m < 2; m++)
        begin
            for (int i = 0; i < bdi_lss_pkg::NUM_CANDS; i++)
            begin
                elig[m][i] = bdi_lss_pkg::cand_used(1'(m), i)
                    && flags_new[bdi_lss_pkg::FLAG_W'(bdi_lss_pkg::cand_flag(1'(m), i))]
                    && (bdi_lss_pkg::cand_size(1'(m), i) < bdi_lss_pkg::LINE_BYTES);
            end
        end
        for (int m = 0; m < 2; m++)
        begin
            for (int i = 0; i < bdi_lss_pkg::NUM_CANDS; i++)
            begin
                beaten = 1'b0;
                for (int j = 0; j < bdi_lss_pkg::NUM_CANDS; j++)
                begin
                    if ((j != i) && elig[m][j] && bdi_lss_pkg::cand_beats(1'(m), j, i))
                        beaten = 1'b1;
                end
                win[m][i] = elig[m][i] && !beaten;
            end
        end
    end

    assign sel        = use_extra_reg ? win[1] : win[0];
    assign compressed = |sel;

    // Code and size of the single winner, or the uncompressed fallback.
    always_comb
    begin
        best_code = bdi_lss_pkg::CODE_NONE;
        best_size = bdi_lss_pkg::line_size_t'(bdi_lss_pkg::LINE_BYTES);
        for (int i = 0; i < bdi_lss_pkg::NUM_CANDS; i++)
        begin
            if (sel[i])
            begin
                best_code = bdi_lss_pkg::code_t'(i);
                best_size = bdi_lss_pkg::line_size_t'(bdi_lss_pkg::cand_size(use_extra_reg, i));
            end
        end
    end

    // Page accounting including the current line; totals saturate past overflow.
    always_comb
    begin
        sum_add = bdi_lss_pkg::sum_ext_t'(page_sum_reg) + bdi_lss_pkg::sum_ext_t'(best_size);
        sum_sat = (sum_add > bdi_lss_pkg::sum_ext_t'(bdi_lss_pkg::SUM_CAP))
                ? bdi_lss_pkg::SUM_CAP : sum_add[bdi_lss_pkg::SUM_W-1:0];
        cnt_add = bdi_lss_pkg::cnt_ext_t'(page_cnt_reg) + bdi_lss_pkg::cnt_ext_t'(1);
        cnt_sat = (cnt_add > bdi_lss_pkg::cnt_ext_t'(bdi_lss_pkg::CNT_CAP))
                ? bdi_lss_pkg::CNT_CAP : cnt_add[bdi_lss_pkg::CNT_W-1:0];
        good_sat = (compressed && (page_good_reg != bdi_lss_pkg::GOOD_CAP))
                 ? page_good_reg + bdi_lss_pkg::good_t'(1) : page_good_reg;
        page_total = bdi_lss_pkg::total_t'(sum_sat)
                   + bdi_lss_pkg::total_t'(cnt_sat >> 1);
        page_ovf   = page_total > bdi_lss_pkg::PAGE_TOT;
        page_bytes = page_ovf ? bdi_lss_pkg::PAGE_CLIP
                   : page_total[bdi_lss_pkg::PAGE_OUT_W-1:0];
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_extra_reg <= 1'b0;
        else if (cfg_write)
            use_extra_reg <= cfg_data;
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_xfer)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_word_reg     <= line_word;
            s1_line_end_reg <= line_end;
            s1_page_end_reg <= page_end;
        end
    end

    // Line and page state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            flags_reg         <= '1;
            page_sum_reg      <= '0;
            page_cnt_reg      <= '0;
            page_good_reg     <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_ends)
            begin
                first_pending_reg <= 1'b1;
                flags_reg         <= '1;
                if (s1_page_end_reg)
                begin
                    page_sum_reg  <= '0;
                    page_cnt_reg  <= '0;
                    page_good_reg <= '0;
                end
                else
                begin
                    page_sum_reg  <= sum_sat;
                    page_cnt_reg  <= cnt_sat;
                    page_good_reg <= good_sat;
                end
            end
            else
            begin
                first_pending_reg <= 1'b0;
                flags_reg         <= flags_new;
            end
        end
    end

    // Base word of the current line.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            first_word_reg <= base_word;
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result register payload; page fields read zero except on a page end.
    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            code_reg          <= best_code;
            size_reg          <= best_size;
            compressed_reg    <= compressed;
            page_valid_reg    <= s1_page_end_reg;
            page_bytes_reg    <= s1_page_end_reg ? page_bytes : '0;
            page_good_out_reg <= s1_page_end_reg ? good_sat : '0;
            page_ovf_reg      <= s1_page_end_reg && page_ovf;
        end
    end

    assign out_valid             = out_valid_reg;
    assign option_code           = code_reg;
    assign line_bytes_out        = size_reg;
    assign line_was_compressed   = compressed_reg;
    assign page_valid            = page_valid_reg;
    assign page_bytes_out        = page_bytes_reg;
    assign page_lines_compressed = page_good_out_reg;
    assign page_overflowed       = page_ovf_reg;

    // Checks on the selector's own logic.
    `BDI_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_reg, "stall with empty input register")
    `BDI_ASSERT(a_single_winner, s1_valid_reg |-> $onehot0(sel), "more than one winning option")
    `BDI_ASSERT(a_none_is_full, out_valid && !line_was_compressed |-> option_code == bdi_lss_pkg::CODE_NONE && line_bytes_out == bdi_lss_pkg::LINE_BYTES, "uncompressed line with wrong code or size")
    `BDI_ASSERT(a_page_quiet, out_valid && !page_valid |-> page_bytes_out == 13'd0 && page_lines_compressed == 7'd0 && !page_overflowed, "page fields set without page end")
    `BDI_ASSERT(a_ovf_clamped, out_valid && page_overflowed |-> page_bytes_out == bdi_lss_pkg::PAGE_CLIP, "overflowed page total not clamped")

endmodule

`default_nettype wire

// File: verif/bdi_lss_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the line size selector: predicts each line result and compares it.
module bdi_lss_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] line_word,
    input  logic        line_end,
    input  logic        page_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  option_code,
    input  logic [6:0]  line_bytes_out,
    input  logic        line_was_compressed,
    input  logic        page_valid,
    input  logic [12:0] page_bytes_out,
    input  logic [6:0]  page_lines_compressed,
    input  logic        page_overflowed,
    output int          fail_count,
    output int          pending
);

    localparam bdi_lss_pkg::code_t CODE_REP_FIRST = 5'd1;
    localparam int    BASIC_OPTIONS  = 6;
    localparam int    WIDE_OPTIONS   = 11;
    localparam int    COUNT_TOP      = 24'hFF_FFFF;

    // One expected line result, page fields included.
    typedef struct {
        bdi_lss_pkg::code_t       code;
        bdi_lss_pkg::line_size_t  size;
        logic                     compressed;
        logic                     page_done;
        bdi_lss_pkg::page_bytes_t page_total;
        bdi_lss_pkg::good_t       page_good;
        logic                     page_clamped;
    } line_result_t;

    line_result_t result_q[$];

    // Shadow of the option set register and of the block's line and page state.
    bit                  use_wide;
    logic [63:0]         base_word;
    bdi_lss_pkg::flags_t live_flags;
    int                  words_seen;
    int                  page_sum;
    int                  page_lines;
    int                  page_good;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Sign-extends the low k bytes of a word to 64 bits.
    function automatic logic [63:0] widen_elem(input logic [63:0] v, input int k);
        logic [63:0] m;
        if (k >= 8)
            return v;
        m = (64'd1 << (8 * k)) - 64'd1;
        v = v & m;
        if (v[8 * k - 1])
            v = v | ~m;
        return v;
    endfunction

    // Flag bit that tracks base size k with delta size d.
    function automatic int delta_flag(input int k, input int d);
        if (k == 8)
            return bdi_lss_pkg::FLAG_B8_FIRST + d - 1;
        if (k == 4)
            return bdi_lss_pkg::FLAG_B4_FIRST + d - 1;
        return bdi_lss_pkg::FLAG_B2;
    endfunction

    // Base and delta sizes of the i-th base-delta option of the active set.
    task automatic option_shape(input bit wide, input int i, output int k, output int d);
        if (wide)
        begin
            if (i < 7)
            begin
                k = 8;
                d = i + 1;
            end
            else if (i < 10)
            begin
                k = 4;
                d = i - 6;
            end
            else
            begin
                k = 2;
                d = 1;
            end
        end
        else
        begin
            case (i)
                0: begin k = 8; d = 1; end
                1: begin k = 8; d = 2; end
                2: begin k = 8; d = 4; end
                3: begin k = 4; d = 1; end
                4: begin k = 4; d = 2; end
                default: begin k = 2; d = 1; end
            endcase
        end
    endtask

    // Clears every option that this word rules out.
    function automatic bdi_lss_pkg::flags_t rule_out(input bdi_lss_pkg::flags_t f,
                                                     input logic [63:0] first,
                                                     input logic [63:0] w);
        int          klog;
        int          k;
        int          j;
        int          d;
        logic [63:0] base;
        logic [63:0] elem;
        logic [63:0] diff;
        if (w != 64'd0)
            f[bdi_lss_pkg::FLAG_ZERO] = 1'b0;
        for (klog = 0; klog < 4; klog++)
        begin
            k = 1 << klog;
            base = widen_elem(first, k);
            for (j = 0; j < 8 / k; j++)
            begin
                elem = widen_elem(w >> (8 * k * j), k);
                diff = base - elem;
                if (elem != base)
                    f[bdi_lss_pkg::FLAG_REP1 + klog] = 1'b0;
                for (d = 1; d < k; d++)
                    if ((diff >> (8 * d)) != 64'd0)
                        f[delta_flag(k, d)] = 1'b0;
            end
        end
        return f;
    endfunction

    function automatic int sat_count(input int v);
        return (v > COUNT_TOP) ? COUNT_TOP : v;
    endfunction

    // Updates the line state with one accepted word and queues the line result at its end.
    task automatic predict_word(input logic [63:0] w, input logic le, input logic pe);
        line_result_t r;
        int           best;
        int           sz;
        int           i;
        int           k;
        int           d;
        int           total;
        if (words_seen == 0)
            base_word = w;
        live_flags = rule_out(live_flags, base_word, w);
        if (words_seen < 7)
            words_seen++;
        if (le || pe)
        begin
            // Smallest encoding wins; the strict compare keeps the lowest code on ties.
            best = bdi_lss_pkg::LINE_BYTES;
            r.code = bdi_lss_pkg::CODE_NONE;
            if (live_flags[bdi_lss_pkg::FLAG_ZERO])
            begin
                best = 1;
                r.code = bdi_lss_pkg::CODE_ZERO;
            end
            for (i = 0; i < 4; i++)
            begin
                sz = 1 << i;
                if (live_flags[bdi_lss_pkg::FLAG_REP1 + i] && sz < best)
                begin
                    best = sz;
                    r.code = bdi_lss_pkg::code_t'(CODE_REP_FIRST + i);
                end
            end
            for (i = 0; i < (use_wide ? WIDE_OPTIONS : BASIC_OPTIONS); i++)
            begin
                option_shape(use_wide, i, k, d);
                sz = k + (bdi_lss_pkg::LINE_BYTES / k) * d;
                if (live_flags[delta_flag(k, d)] && sz < best)
                begin
                    best = sz;
                    r.code = bdi_lss_pkg::code_t'(bdi_lss_pkg::CODE_BD_FIRST + i);
                end
            end

            page_sum = sat_count(page_sum + best);
            page_lines = sat_count(page_lines + 1);
            if (best < bdi_lss_pkg::LINE_BYTES)
                page_good = sat_count(page_good + 1);

            r.size = bdi_lss_pkg::line_size_t'(best);
            r.compressed = (best < bdi_lss_pkg::LINE_BYTES);
            r.page_done = pe;
            r.page_total = '0;
            r.page_good = '0;
            r.page_clamped = 1'b0;

            // Page close: half a byte of index per line, clamped at the page size.
            if (pe)
            begin
                total = page_sum + page_lines / 2;
                r.page_clamped = (total > bdi_lss_pkg::PAGE_BYTES);
                if (total > bdi_lss_pkg::PAGE_BYTES)
                    total = bdi_lss_pkg::PAGE_BYTES;
                r.page_total = bdi_lss_pkg::page_bytes_t'(total);
                r.page_good = (page_good > int'(bdi_lss_pkg::GOOD_CAP))
                            ? bdi_lss_pkg::GOOD_CAP : bdi_lss_pkg::good_t'(page_good);
                page_sum = 0;
                page_lines = 0;
                page_good = 0;
            end
            result_q.push_back(r);
            live_flags = '1;
            words_seen = 0;
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        line_result_t want;
        if (!rst_n)
        begin
            use_wide = 1'b0;
            base_word = '0;
            live_flags = '1;
            words_seen = 0;
            page_sum = 0;
            page_lines = 0;
            page_good = 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_write)
                use_wide = cfg_data;

            // Result transfer: compare with the oldest expectation.
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                    report($sformatf("result with no line pending, option_code %0d",
                                     option_code));
                else
                begin
                    want = result_q.pop_front();
                    check_field("option_code", option_code, want.code);
                    check_field("line_bytes_out", line_bytes_out, want.size);
                    check_field("line_was_compressed", line_was_compressed,
                                want.compressed);
                    check_field("page_valid", page_valid, want.page_done);
                    check_field("page_bytes_out", page_bytes_out, want.page_total);
                    check_field("page_lines_compressed", page_lines_compressed,
                                want.page_good);
                    check_field("page_overflowed", page_overflowed, want.page_clamped);
                end
            end

            // Input transfer.
            if (in_valid && !in_stall)
                predict_word(line_word, line_end, page_end);
        end
        pending = result_q.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the line size selector: clock, reset, stimulus and verdict.
module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 80;

    typedef enum int {PAT_ZERO, PAT_REPEAT, PAT_DELTA, PAT_NOISE} pattern_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] line_word;
    logic        line_end;
    logic        page_end;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  option_code;
    logic [6:0]  line_bytes_out;
    logic        line_was_compressed;
    logic        page_valid;
    logic [12:0] page_bytes_out;
    logic [6:0]  page_lines_compressed;
    logic        page_overflowed;

    int fail_count;
    int pending;
    int words_sent = 0;
    int quiet_cycles = 0;
    int tx_idle_pct;
    int rx_busy_pct;
    bit hold_req;
    bit hold_done;

    bdi_line_size_selector_core uut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .line_word             (line_word),
        .line_end              (line_end),
        .page_end              (page_end),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .option_code           (option_code),
        .line_bytes_out        (line_bytes_out),
        .line_was_compressed   (line_was_compressed),
        .page_valid            (page_valid),
        .page_bytes_out        (page_bytes_out),
        .page_lines_compressed (page_lines_compressed),
        .page_overflowed       (page_overflowed)
    );

    bdi_lss_checker line_check
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .line_word             (line_word),
        .line_end              (line_end),
        .page_end              (page_end),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .option_code           (option_code),
        .line_bytes_out        (line_bytes_out),
        .line_was_compressed   (line_was_compressed),
        .page_valid            (page_valid),
        .page_bytes_out        (page_bytes_out),
        .page_lines_compressed (page_lines_compressed),
        .page_overflowed       (page_overflowed),
        .fail_count            (fail_count),
        .pending               (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle and stall lengths: mostly short, now and then long.
    function automatic int pick_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offers one word and waits for its transfer.
    task automatic send_word(input logic [63:0] w, input logic le, input logic pe);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? pick_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        line_word <= w;
        line_end <= le;
        page_end <= pe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Builds a line of the given pattern and sends its first nwords words.
    task automatic send_line(input pattern_t pat, input int nwords, input bit pg,
                             input bit pg_only);
        logic [7:0]  line_bytes [80];
        logic [63:0] base;
        logic [63:0] elem;
        logic [63:0] mask;
        logic [63:0] w;
        int          k;
        int          d;
        int          j;
        int          b;
        int          pos;
        base = {$urandom, $urandom};
        for (b = 0; b < 80; b++)
            line_bytes[b] = 8'($urandom_range(255));
        case (pat)
            PAT_ZERO:
            begin
                for (b = 0; b < 80; b++)
                    line_bytes[b] = 8'h00;
                if ($urandom_range(4) == 0)
                    line_bytes[$urandom_range(79)] = 8'($urandom_range(255, 1));
            end
            PAT_REPEAT:
            begin
                k = 1 << $urandom_range(3);
                for (j = 0; j < 80 / k; j++)
                    for (b = 0; b < k; b++)
                        line_bytes[j * k + b] = base[8 * b +: 8];
                if ($urandom_range(9) == 0)
                begin
                    pos = $urandom_range(79);
                    line_bytes[pos] = line_bytes[pos] ^ 8'h01;
                end
            end
            PAT_DELTA:
            begin
                // Elements sit a small distance below the base, sometimes above it,
                // and now and then one element is unrelated.
                k = 2 << $urandom_range(2);
                d = $urandom_range(k - 1, 1);
                mask = (64'd1 << (8 * d)) - 64'd1;
                for (j = 0; j < 80 / k; j++)
                begin
                    if (j == 0)
                        elem = base;
                    else if ($urandom_range(19) == 0)
                        elem = {$urandom, $urandom};
                    else if ($urandom_range(3) == 0)
                        elem = base + ({$urandom, $urandom} & mask);
                    else
                        elem = base - ({$urandom, $urandom} & mask);
                    for (b = 0; b < k; b++)
                        line_bytes[j * k + b] = elem[8 * b +: 8];
                end
            end
            default:
            begin
            end
        endcase
        for (j = 0; j < nwords; j++)
        begin
            for (b = 0; b < 8; b++)
                w[8 * b +: 8] = line_bytes[8 * j + b];
            send_word(w, (j == nwords - 1) && !pg_only, (j == nwords - 1) && pg);
        end
    endtask

    // Mostly well-formed eight-word lines, some short or long, some closing a page.
    task automatic send_random_line();
        pattern_t pat;
        int       r;
        int       n;
        bit       pg;
        bit       pg_only;
        r = $urandom_range(99);
        pat = (r < 15) ? PAT_ZERO : (r < 40) ? PAT_REPEAT : (r < 80) ? PAT_DELTA : PAT_NOISE;
        n = ($urandom_range(9) < 8) ? 8 : $urandom_range(10, 1);
        pg = ($urandom_range(99) < 12);
        pg_only = pg && ($urandom_range(3) == 0);
        send_line(pat, n, pg, pg_only);
    endtask

    // Writes the option set register once the block has drained.
    task automatic write_option_set(input logic wide);
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= wide;
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    // Result side: random stall stretches, plus one long hold-off on request.
    initial
    begin : receiver
        int len;
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                len = pick_len();
                out_stall <= ($urandom_range(99) < rx_busy_pct);
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [63:0] a;
        int          ph;
        int          j;
        int          target;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        line_word = '0;
        line_end = 1'b0;
        page_end = 1'b0;
        hold_req = 1'b0;
        tx_idle_pct = 20;
        rx_busy_pct = 20;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed lines with the original option set: zero, each repeat grain,
        // base-delta hits, a delta of the wrong sign, a page end without line end.
        write_option_set(1'b0);
        a = 64'h0123_4567_89AB_CDEF;
        send_word(64'h0, 1'b1, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_word(64'h1234_1234_1234_1234, 1'b1, 1'b0);
        send_word(64'h89AB_CDEF_89AB_CDEF, 1'b1, 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b1, 1'b0);
        send_word(a, 1'b0, 1'b0);
        send_word(a - 64'd5, 1'b1, 1'b0);
        send_word(a, 1'b0, 1'b0);
        send_word(a - 64'h1234, 1'b1, 1'b1);
        send_word(a, 1'b0, 1'b0);
        send_word(a - 64'h0012_3456, 1'b1, 1'b0);
        send_word(a, 1'b0, 1'b0);
        send_word(a + 64'd1, 1'b1, 1'b0);
        send_word(64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 1'b1);

        // Directed lines with the extended option set.
        write_option_set(1'b1);
        send_word(a, 1'b0, 1'b0);
        send_word(a - 64'h0012_3456, 1'b1, 1'b0);
        send_word(a, 1'b0, 1'b0);
        send_word(a - 64'h0000_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_word({32'h3FFE_FDFD, 32'h4000_0000}, 1'b0, 1'b0);
        send_word({32'h3FFD_0000, 32'h3FFF_FF01}, 1'b1, 1'b0);
        send_word(64'h0, 1'b1, 1'b1);

        // Random phases, each under its own register setting and idle rates.
        for (ph = 0; ph < PHASES; ph++)
        begin
            write_option_set((ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(1)));
            if (ph == 2)
            begin
                tx_idle_pct = 0;
                rx_busy_pct = 0;
            end
            else
            begin
                tx_idle_pct = $urandom_range(40, 5);
                rx_busy_pct = $urandom_range(40, 5);
            end
            // The receiver holds off while lines keep coming, so the input stalls.
            if (ph == 1)
                hold_req = 1'b1;
            // A page of incompressible lines runs past the page size.
            if (ph == 3)
                for (j = 0; j < 66; j++)
                    send_line(PAT_NOISE, 2, j == 65, 1'b0);
            // More compressed lines in one page than the page counter can show.
            if (ph == 4)
                for (j = 0; j < 130; j++)
                    send_line(PAT_REPEAT, 1, j == 129, 1'b0);
            target = words_sent + PHASE_ITEMS;
            while (words_sent < target)
                send_random_line();
        end

        // Drain and give the verdict.
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: bdi_line_size_selector_core.f
+incdir+design
design/bdi_lss_pkg.sv
design/bdi_line_size_selector_core.sv
verif/bdi_lss_checker.sv
verif/tb.sv
